[hdl/hsv_to_rgb_converter_unit_assert.svh]
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSV2RGB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv2rgb: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HSV2RGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsv2rgb: next-cycle check failed");

`endif

[hdl/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 13;
   localparam int HUE_FULL     = 5760;
   localparam int SECTOR_SPAN  = 960;
   localparam int FRAC_BITS    = $clog2(SECTOR_SPAN);

   localparam longint unsigned CH_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
   // q and t share one denominator: one sector span times full scale
   localparam longint unsigned DEN    = SECTOR_SPAN * CH_MAX;
   localparam int DEN_BITS = $clog2(DEN + 64'd1);

   // rounding numerators 2*v*a + d, divided by 2*d
   localparam int XP_BITS = $clog2(2 * CH_MAX * CH_MAX + CH_MAX + 64'd1);
   localparam int XQ_BITS = $clog2(2 * CH_MAX * DEN + DEN + 64'd1);

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } req_payload_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rsp_payload_type;

   typedef struct packed {
      logic load_est;
      logic load_fix;
   } stage_ctl_type;

endpackage

[hdl/hsv2rgb_round_div.sv]
// Two-stage divide by a constant: reciprocal estimate, then one-step correction.
module hsv2rgb_round_div #(
   parameter int              X_BITS  = 17,
   parameter longint unsigned DIVISOR = 510
) (
   input  logic                                   clock,
   input  hsv2rgb_pkg::stage_ctl_type             ctl,
   input  logic [X_BITS-1:0]                      x,
   output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]   q
);

   localparam int              CB         = hsv2rgb_pkg::CHANNEL_BITS;
   localparam longint unsigned RECIP      = (64'd1 << X_BITS) / DIVISOR;
   localparam int              RECIP_BITS = $clog2(RECIP + 64'd1);
   localparam int              PROD_BITS  = X_BITS + RECIP_BITS;
   localparam logic [X_BITS-1:0]     DIV_C   = X_BITS'(DIVISOR);
   localparam logic [RECIP_BITS-1:0] RECIP_C = RECIP_BITS'(RECIP);

   logic [PROD_BITS-1:0] prod;
   logic [X_BITS-1:0]    x_in, x_ff;
   logic [CB-1:0]        est_in, est_ff;
   logic [X_BITS-1:0]    rem;
   logic [CB-1:0]        q_in, q_ff;

   // floor reciprocal: estimate is the true quotient or one below it
   assign prod   = PROD_BITS'(x) * PROD_BITS'(RECIP_C);
   assign est_in = prod[X_BITS +: CB];
   assign x_in   = x;

   assign rem  = x_ff - X_BITS'(X_BITS'(est_ff) * DIV_C);
   assign q_in = (rem >= DIV_C) ? est_ff + CB'(1) : est_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_est) begin
         x_ff   <= x_in;
         est_ff <= est_in;
      end
      if (ctl.load_fix) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

[hdl/hsv_to_rgb_converter_unit.sv]
// Channel  Ports                                Payload
// req      req_valid / req_stall / req_payload  hue, saturation, brightness
// rsp      rsp_valid / rsp_stall / rsp_payload  red, green, blue
//
// Six register stages: hue sector, s*f products, v products, reciprocal
// estimate, quotient correction, channel select.
// One pixel per clock sustained while rsp_stall is low; the stage valid bits fill bubbles.
// Synchronous active-high reset clears the valid bits only.
// rsp_stall holds only the stages that are full; req_stall rises when all are full and rsp_stall is high.
module hsv_to_rgb_converter_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  hsv2rgb_pkg::req_payload_type req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output hsv2rgb_pkg::rsp_payload_type rsp_payload
);

   `include "hsv_to_rgb_converter_unit_assert.svh"

   localparam int CB  = hsv2rgb_pkg::CHANNEL_BITS;
   localparam int HB  = hsv2rgb_pkg::HUE_BITS;
   localparam int FB  = hsv2rgb_pkg::FRAC_BITS;
   localparam int DB  = hsv2rgb_pkg::DEN_BITS;
   localparam int XPB = hsv2rgb_pkg::XP_BITS;
   localparam int XQB = hsv2rgb_pkg::XQ_BITS;
   localparam int SPAN = hsv2rgb_pkg::SECTOR_SPAN;
   localparam int NSTAGE = 6;

   typedef enum logic [2:0] {
      SEC_RED_YEL,
      SEC_YEL_GRN,
      SEC_GRN_CYN,
      SEC_CYN_BLU,
      SEC_BLU_MAG,
      SEC_MAG_RED
   } sector_type;

   // ---- stage valid bits and advance chain
   logic [NSTAGE-1:0] vld_in, vld_ff, rdy, vld_src;
   hsv2rgb_pkg::stage_ctl_type div_ctl;

   always_comb begin
      rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign vld_src = {vld_ff[NSTAGE-2:0], req_valid};
   assign vld_in  = (rdy & vld_src) | (~rdy & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NSTAGE-1];
   assign div_ctl.load_est = rdy[3];
   assign div_ctl.load_fix = rdy[4];

   // ---- stage 1: hue wrap, sector and fraction
   logic [HB-1:0] hue_wrap, sec_base;
   sector_type    s1_sec_in, s1_sec_ff;
   logic [FB-1:0] s1_frac_in, s1_frac_ff;
   logic [CB-1:0] s1_sat_in, s1_sat_ff, s1_val_in, s1_val_ff;
   logic          s1_grey_in, s1_grey_ff;

   always_comb begin
      hue_wrap = (req_payload.hue >= HB'(hsv2rgb_pkg::HUE_FULL)) ? '0 : req_payload.hue;
      if (hue_wrap >= HB'(5 * SPAN)) begin
         s1_sec_in = SEC_MAG_RED;
         sec_base  = HB'(5 * SPAN);
      end else if (hue_wrap >= HB'(4 * SPAN)) begin
         s1_sec_in = SEC_BLU_MAG;
         sec_base  = HB'(4 * SPAN);
      end else if (hue_wrap >= HB'(3 * SPAN)) begin
         s1_sec_in = SEC_CYN_BLU;
         sec_base  = HB'(3 * SPAN);
      end else if (hue_wrap >= HB'(2 * SPAN)) begin
         s1_sec_in = SEC_GRN_CYN;
         sec_base  = HB'(2 * SPAN);
      end else if (hue_wrap >= HB'(SPAN)) begin
         s1_sec_in = SEC_YEL_GRN;
         sec_base  = HB'(SPAN);
      end else begin
         s1_sec_in = SEC_RED_YEL;
         sec_base  = '0;
      end
   end

   assign s1_frac_in = FB'(hue_wrap - sec_base);
   assign s1_sat_in  = req_payload.saturation;
   assign s1_val_in  = req_payload.brightness;
   assign s1_grey_in = (req_payload.saturation == '0);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_sec_ff  <= s1_sec_in;
         s1_frac_ff <= s1_frac_in;
         s1_sat_ff  <= s1_sat_in;
         s1_val_ff  <= s1_val_in;
         s1_grey_ff <= s1_grey_in;
      end
   end

   // ---- stage 2: 1-s, 1-s*f, 1-s*(1-f) in scaled integers
   logic [CB-1:0] s2_pp_in, s2_pp_ff, s2_val_ff;
   logic [DB-1:0] s2_aq_in, s2_aq_ff, s2_at_in, s2_at_ff;
   sector_type    s2_sec_ff;
   logic          s2_grey_ff;

   assign s2_pp_in = CB'(hsv2rgb_pkg::CH_MAX) - s1_sat_ff;
   assign s2_aq_in = DB'(hsv2rgb_pkg::DEN) - DB'(s1_sat_ff) * DB'(s1_frac_ff);
   assign s2_at_in = DB'(hsv2rgb_pkg::DEN)
                   - DB'(s1_sat_ff) * (DB'(SPAN) - DB'(s1_frac_ff));

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_pp_ff   <= s2_pp_in;
         s2_aq_ff   <= s2_aq_in;
         s2_at_ff   <= s2_at_in;
         s2_val_ff  <= s1_val_ff;
         s2_sec_ff  <= s1_sec_ff;
         s2_grey_ff <= s1_grey_ff;
      end
   end

   // ---- stage 3: rounding numerators 2*v*a + d
   logic [XPB-1:0] s3_xp_in, s3_xp_ff;
   logic [XQB-1:0] s3_xq_in, s3_xq_ff, s3_xt_in, s3_xt_ff;
   logic [CB-1:0]  s3_val_ff;
   sector_type     s3_sec_ff;
   logic           s3_grey_ff;

   assign s3_xp_in = XPB'({s2_val_ff, 1'b0}) * XPB'(s2_pp_ff) + XPB'(hsv2rgb_pkg::CH_MAX);
   assign s3_xq_in = XQB'({s2_val_ff, 1'b0}) * XQB'(s2_aq_ff) + XQB'(hsv2rgb_pkg::DEN);
   assign s3_xt_in = XQB'({s2_val_ff, 1'b0}) * XQB'(s2_at_ff) + XQB'(hsv2rgb_pkg::DEN);

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_xp_ff   <= s3_xp_in;
         s3_xq_ff   <= s3_xq_in;
         s3_xt_ff   <= s3_xt_in;
         s3_val_ff  <= s2_val_ff;
         s3_sec_ff  <= s2_sec_ff;
         s3_grey_ff <= s2_grey_ff;
      end
   end

   // ---- stages 4 and 5: constant dividers
   logic [CB-1:0] term_p, term_q, term_t;

   hsv2rgb_round_div #(
      .X_BITS  (XPB),
      .DIVISOR (2 * hsv2rgb_pkg::CH_MAX)
   ) u_div_p (
      .clock (clock),
      .ctl   (div_ctl),
      .x     (s3_xp_ff),
      .q     (term_p)
   );

   hsv2rgb_round_div #(
      .X_BITS  (XQB),
      .DIVISOR (2 * hsv2rgb_pkg::DEN)
   ) u_div_q (
      .clock (clock),
      .ctl   (div_ctl),
      .x     (s3_xq_ff),
      .q     (term_q)
   );

   hsv2rgb_round_div #(
      .X_BITS  (XQB),
      .DIVISOR (2 * hsv2rgb_pkg::DEN)
   ) u_div_t (
      .clock (clock),
      .ctl   (div_ctl),
      .x     (s3_xt_ff),
      .q     (term_t)
   );

   logic [CB-1:0] s4_val_ff, s5_val_ff;
   sector_type    s4_sec_ff, s5_sec_ff;
   logic          s4_grey_ff, s5_grey_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_val_ff  <= s3_val_ff;
         s4_sec_ff  <= s3_sec_ff;
         s4_grey_ff <= s3_grey_ff;
      end
      if (rdy[4]) begin
         s5_val_ff  <= s4_val_ff;
         s5_sec_ff  <= s4_sec_ff;
         s5_grey_ff <= s4_grey_ff;
      end
   end

   // ---- stage 6: channel order by sector, grey override
   hsv2rgb_pkg::rsp_payload_type rsp_payload_in, rsp_payload_ff;
   logic s6_grey_ff;

   always_comb begin
      case (s5_sec_ff)
         SEC_RED_YEL: rsp_payload_in = '{red: s5_val_ff, green: term_t, blue: term_p};
         SEC_YEL_GRN: rsp_payload_in = '{red: term_q, green: s5_val_ff, blue: term_p};
         SEC_GRN_CYN: rsp_payload_in = '{red: term_p, green: s5_val_ff, blue: term_t};
         SEC_CYN_BLU: rsp_payload_in = '{red: term_p, green: term_q, blue: s5_val_ff};
         SEC_BLU_MAG: rsp_payload_in = '{red: term_t, green: term_p, blue: s5_val_ff};
         default:     rsp_payload_in = '{red: s5_val_ff, green: term_p, blue: term_q};
      endcase
      if (s5_grey_ff) begin
         rsp_payload_in = '{red: s5_val_ff, green: s5_val_ff, blue: s5_val_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         rsp_payload_ff <= rsp_payload_in;
         s6_grey_ff     <= s5_grey_ff;
      end
   end

   assign rsp_payload = rsp_payload_ff;

   // ---- assertions
   `HSV2RGB_ASSERT_NOW(a_stall_only_when_full, clock, reset,
      req_stall, (vld_ff == {NSTAGE{1'b1}}) && rsp_stall)
   `HSV2RGB_ASSERT_NOW(a_grey_equal_channels, clock, reset,
      rsp_valid && s6_grey_ff,
      (rsp_payload.red == rsp_payload.green) && (rsp_payload.green == rsp_payload.blue))
   `HSV2RGB_ASSERT_NEXT(a_divider_stage_kept, clock, reset,
      vld_ff[4] && !rdy[4], vld_ff[4])

endmodule
